/* sv/slpg_pkg.sv */
// Package with the shared types, codes and constants of the line pixel generator.
package slpg_pkg;

    localparam int COORD_BITS     = 10;
    localparam int ERR_BITS       = COORD_BITS + 2;
    localparam int COLOR_BITS     = 16;
    localparam int CFG_INDEX_BITS = 1;
    localparam int Q_DEPTH        = 4;
    localparam int Q_PTR_BITS     = $clog2(Q_DEPTH);
    localparam int Q_CNT_BITS     = Q_PTR_BITS + 1;

    typedef logic [COORD_BITS-1:0]     coord_t;
    typedef logic signed [ERR_BITS-1:0] err_t;
    typedef logic [COLOR_BITS-1:0]     color_t;
    typedef logic [CFG_INDEX_BITS-1:0] cfg_index_t;
    typedef logic [2:0]                step_mode_t;
    typedef logic [1:0]                status_t;

    localparam coord_t COORD_ONE     = coord_t'(1);
    localparam coord_t X_LIMIT_RESET = coord_t'(240);
    localparam coord_t Y_LIMIT_RESET = coord_t'(320);

    // register indexes
    localparam cfg_index_t REG_X_LIMIT = cfg_index_t'(0);
    localparam cfg_index_t REG_Y_LIMIT = cfg_index_t'(1);

    // action codes
    localparam logic ACT_START = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // result status codes
    localparam status_t ST_PIXEL  = 2'd0;
    localparam status_t ST_REJECT = 2'd1;
    localparam status_t ST_IDLE   = 2'd2;

    // step modes; staircase modes have bit 2 set
    localparam step_mode_t MODE_VERT = 3'd0;
    localparam step_mode_t MODE_HORZ = 3'd1;
    localparam step_mode_t MODE_STAIR = 3'd4;
    localparam int MODE_XDEC_BIT = 0;
    localparam int MODE_YDEC_BIT = 1;

    typedef struct packed {
        logic   action;
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        color_t line_color;
    } in_item_t;

    typedef struct packed {
        status_t status;
        coord_t  pixel_x;
        coord_t  pixel_y;
        color_t  pixel_color;
        logic    final_pixel;
    } out_item_t;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_REJECT = 2'd1,
        CMD_TICK   = 2'd2
    } cmd_kind_t;

    // classified command handed from the front to the back
    typedef struct packed {
        cmd_kind_t  kind;
        step_mode_t mode;
        coord_t     cur_x;
        coord_t     cur_y;
        coord_t     goal_x;
        coord_t     goal_y;
        coord_t     delta_x;
        coord_t     delta_y;
        color_t     color;
    } cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

endpackage

/* sv/stepwise_line_pixel_generator.sv */
// Top level of the stepwise line pixel generator: front end, command queue and line stepper.
//
//   channel  direction  ports                                    payload
//   s_       in         s_valid, s_ready, s_data                 in_item_t (start or tick)
//   m_       out        m_valid, m_ready, m_data                 out_item_t (one per item)
//   cfg_     in         cfg_valid, cfg_ready, cfg_index, cfg_data limit register write
//
// One transaction in gives one transaction out; the stepper takes one queued command per
// cycle while the result register is empty or being taken, so the sustained rate is one
// item per cycle. Each accepted item goes from the queue head into the result register.
// aresetn is synchronous and active low; it empties the queue, drops any line in
// progress and restores the limits to 240 and 320. cfg_ready is always high.
// A stall on m_ready holds the result register and the stepper; the four-entry queue
// absorbs incoming transactions until it fills, then s_ready drops.
module stepwise_line_pixel_generator import slpg_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    // input items
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    // result items
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data,
    // limit registers
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  coord_t     cfg_data
);

    q_status_t q_status;
    logic      push, pop;
    cmd_t      push_cmd, head_cmd;

    // classify each transaction: tick, rejected start or valid start with its setup
    slpg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // decouple the two sides so each can stall on its own
    slpg_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .q_status (q_status)
    );

    // walk the line and register each result
    slpg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_cmd (head_cmd),
        .q_status (q_status),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* sv/slpg_front.sv */
// Front end: limit registers, input acceptance and classification of each item.
module slpg_front import slpg_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  cfg_index_t cfg_index,
    input  coord_t     cfg_data,
    input  q_status_t  q_status,
    output logic       push,
    output cmd_t       push_cmd
);

    coord_t x_limit_reg, y_limit_reg;
    logic   reject;
    logic   x_back, y_back;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_limit_reg <= X_LIMIT_RESET;
            y_limit_reg <= Y_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_X_LIMIT: x_limit_reg <= cfg_data;
                REG_Y_LIMIT: y_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign s_ready = !q_status.full;
    assign push    = s_valid && s_ready;

    assign reject = (s_data.start_x > x_limit_reg) || (s_data.end_x > x_limit_reg) ||
                    (s_data.start_y > y_limit_reg) || (s_data.end_y > y_limit_reg);
    assign x_back = s_data.end_x < s_data.start_x;
    assign y_back = s_data.end_y < s_data.start_y;

    always_comb begin
        push_cmd         = '0;
        push_cmd.color   = s_data.line_color;
        push_cmd.delta_x = x_back ? s_data.start_x - s_data.end_x
                                  : s_data.end_x - s_data.start_x;
        push_cmd.delta_y = y_back ? s_data.start_y - s_data.end_y
                                  : s_data.end_y - s_data.start_y;
        if (s_data.action == ACT_TICK) begin
            push_cmd.kind = CMD_TICK;
        end else if (reject) begin
            push_cmd.kind = CMD_REJECT;
        end else begin
            push_cmd.kind = CMD_START;
        end

        if (s_data.start_x == s_data.end_x) begin
            // vertical: run upward from the smaller y
            push_cmd.mode   = MODE_VERT;
            push_cmd.cur_x  = s_data.start_x;
            push_cmd.goal_x = s_data.start_x;
            push_cmd.cur_y  = y_back ? s_data.end_y : s_data.start_y;
            push_cmd.goal_y = y_back ? s_data.start_y : s_data.end_y;
        end else if (s_data.start_y == s_data.end_y) begin
            push_cmd.mode   = MODE_HORZ;
            push_cmd.cur_y  = s_data.start_y;
            push_cmd.goal_y = s_data.start_y;
            push_cmd.cur_x  = x_back ? s_data.end_x : s_data.start_x;
            push_cmd.goal_x = x_back ? s_data.start_x : s_data.end_x;
        end else begin
            push_cmd.mode                = MODE_STAIR;
            push_cmd.mode[MODE_XDEC_BIT] = x_back;
            push_cmd.mode[MODE_YDEC_BIT] = y_back;
            push_cmd.cur_x               = s_data.start_x;
            push_cmd.cur_y               = s_data.start_y;
            push_cmd.goal_x              = s_data.end_x;
            push_cmd.goal_y              = s_data.end_y;
        end
    end

endmodule

/* sv/slpg_queue.sv */
// Short command queue between the front end and the line stepper.
module slpg_queue import slpg_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  cmd_t      push_cmd,
    input  logic      pop,
    output cmd_t      head_cmd,
    output q_status_t q_status
);

    cmd_t                  mem [Q_DEPTH];
    logic [Q_PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_BITS-1:0] count_reg;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == Q_CNT_BITS'(Q_DEPTH));
    assign head_cmd       = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.full |-> !push)
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        q_status.empty |-> !pop)
        else $error("queue pop while empty");

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= Q_CNT_BITS'(Q_DEPTH))
        else $error("queue count out of range");

endmodule

/* sv/slpg_back.sv */
// Back end: line state, staircase stepping and the result register.
module slpg_back import slpg_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  cmd_t      head_cmd,
    input  q_status_t q_status,
    output logic      pop,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    logic       busy_reg, busy_next;
    coord_t     cur_x_reg, cur_y_reg, goal_x_reg, goal_y_reg;
    coord_t     cur_x_next, cur_y_next, goal_x_next, goal_y_next;
    coord_t     dx_reg, dy_reg, dx_next, dy_next;
    err_t       err_reg, err_next;
    step_mode_t mode_reg, mode_next;
    color_t     color_reg, color_next;
    coord_t     adv_x, adv_y;
    err_t       adv_err;
    logic       last;
    out_item_t  result;
    logic       m_valid_reg;
    out_item_t  m_data_reg;

    assign pop     = !q_status.empty && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // one step of the current line
    always_comb begin
        adv_x   = cur_x_reg;
        adv_y   = cur_y_reg;
        adv_err = err_reg;
        if (mode_reg == MODE_VERT) begin
            adv_y = cur_y_reg + COORD_ONE;
        end else if (mode_reg == MODE_HORZ) begin
            adv_x = cur_x_reg + COORD_ONE;
        end else if (!err_reg[ERR_BITS-1]) begin
            adv_x   = mode_reg[MODE_XDEC_BIT] ? cur_x_reg - COORD_ONE : cur_x_reg + COORD_ONE;
            adv_err = err_reg - $signed({2'b00, dy_reg});
        end else begin
            adv_y   = mode_reg[MODE_YDEC_BIT] ? cur_y_reg - COORD_ONE : cur_y_reg + COORD_ONE;
            adv_err = err_reg + $signed({2'b00, dx_reg});
        end
    end

    always_comb begin
        busy_next   = busy_reg;
        cur_x_next  = cur_x_reg;
        cur_y_next  = cur_y_reg;
        goal_x_next = goal_x_reg;
        goal_y_next = goal_y_reg;
        dx_next     = dx_reg;
        dy_next     = dy_reg;
        err_next    = err_reg;
        mode_next   = mode_reg;
        color_next  = color_reg;
        result      = '0;
        last        = 1'b0;
        unique case (head_cmd.kind)
            CMD_REJECT: begin
                busy_next     = 1'b0;
                result.status = ST_REJECT;
            end
            CMD_START: begin
                cur_x_next  = head_cmd.cur_x;
                cur_y_next  = head_cmd.cur_y;
                goal_x_next = head_cmd.goal_x;
                goal_y_next = head_cmd.goal_y;
                dx_next     = head_cmd.delta_x;
                dy_next     = head_cmd.delta_y;
                err_next    = '0;
                mode_next   = head_cmd.mode;
                color_next  = head_cmd.color;
            end
            CMD_TICK: begin
                if (busy_reg) begin
                    cur_x_next = adv_x;
                    cur_y_next = adv_y;
                    err_next   = adv_err;
                end else begin
                    result.status = ST_IDLE;
                end
            end
            default: ;
        endcase
        if (head_cmd.kind == CMD_START || (head_cmd.kind == CMD_TICK && busy_reg)) begin
            last               = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);
            busy_next          = !last;
            result.status      = ST_PIXEL;
            result.pixel_x     = cur_x_next;
            result.pixel_y     = cur_y_next;
            result.pixel_color = color_next;
            result.final_pixel = last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (pop) begin
                busy_reg    <= busy_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_x_reg  <= '0;
            cur_y_reg  <= '0;
            goal_x_reg <= '0;
            goal_y_reg <= '0;
            dx_reg     <= '0;
            dy_reg     <= '0;
            err_reg    <= '0;
            mode_reg   <= MODE_VERT;
            color_reg  <= '0;
            m_data_reg <= '0;
        end else if (pop) begin
            cur_x_reg  <= cur_x_next;
            cur_y_reg  <= cur_y_next;
            goal_x_reg <= goal_x_next;
            goal_y_reg <= goal_y_next;
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            err_reg    <= err_next;
            mode_reg   <= mode_next;
            color_reg  <= color_next;
            m_data_reg <= result;
        end
    end

    a_final_clears_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && result.final_pixel |=> !busy_reg)
        else $error("line still busy after its final pixel");

    a_code_has_no_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_PIXEL |->
            m_data.pixel_x == '0 && m_data.pixel_y == '0 && !m_data.final_pixel)
        else $error("status code result carries pixel data");

    a_idle_keeps_state: assert property (@(posedge aclk) disable iff (!aresetn)
        pop && head_cmd.kind == CMD_TICK && !busy_reg |=> $stable(cur_x_reg) && !busy_reg)
        else $error("idle tick changed line state");

endmodule

/* tb/tb.sv */
// Self-checking testbench for the stepwise line pixel generator: predictor, driver, monitor.
module tb;
    import slpg_pkg::*;

    // Clock and the single reset at the start of the run.
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always #5 aclk = ~aclk;

    // Every block input holds a known value from time zero.
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    cfg_index_t cfg_index = REG_X_LIMIT;
    coord_t     cfg_data  = '0;

    stepwise_line_pixel_generator dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Items waiting for the driver, and the pixels the predictor says must come back.
    in_item_t  line_cmds[$];
    out_item_t awaited_pixels[$];

    int   pixel_errors = 0;
    int   pixels_seen  = 0;
    logic hold_input   = 1'b0;

    // Shadow of the panel limits, updated when a register write is accepted.
    coord_t lim_x = X_LIMIT_RESET;
    coord_t lim_y = Y_LIMIT_RESET;

    // Predictor copy of the line state.
    logic       ln_busy  = 1'b0;
    coord_t     ln_cx    = '0;
    coord_t     ln_cy    = '0;
    coord_t     ln_gx    = '0;
    coord_t     ln_gy    = '0;
    int         ln_err   = 0;
    int         ln_dx    = 0;
    int         ln_dy    = 0;
    step_mode_t ln_mode  = MODE_VERT;
    color_t     ln_color = '0;

    // Work out the result of one accepted transaction and advance the line state.
    function automatic out_item_t trace_line_step(input in_item_t item);
        out_item_t r;
        int        x1, y1, x2, y2;
        r  = '0;
        x1 = item.start_x;
        y1 = item.start_y;
        x2 = item.end_x;
        y2 = item.end_y;
        if (item.action == ACT_START) begin
            // Any endpoint past the panel drops the line in progress and rejects.
            if (item.start_x > lim_x || item.end_x > lim_x ||
                item.start_y > lim_y || item.end_y > lim_y) begin
                ln_busy  = 1'b0;
                r.status = ST_REJECT;
                return r;
            end
            ln_color = item.line_color;
            ln_err   = 0;
            ln_dx    = (x2 >= x1) ? x2 - x1 : x1 - x2;
            ln_dy    = (y2 >= y1) ? y2 - y1 : y1 - y2;
            if (x1 == x2) begin
                // Vertical: always walk upward from the smaller y.
                ln_mode = MODE_VERT;
                ln_cx   = coord_t'(x1);
                ln_gx   = coord_t'(x1);
                ln_cy   = coord_t'((y1 <= y2) ? y1 : y2);
                ln_gy   = coord_t'((y1 <= y2) ? y2 : y1);
            end else if (y1 == y2) begin
                // Horizontal: always walk right from the smaller x.
                ln_mode = MODE_HORZ;
                ln_cy   = coord_t'(y1);
                ln_gy   = coord_t'(y1);
                ln_cx   = coord_t'((x1 <= x2) ? x1 : x2);
                ln_gx   = coord_t'((x1 <= x2) ? x2 : x1);
            end else begin
                ln_mode = MODE_STAIR;
                ln_mode[MODE_XDEC_BIT] = (x2 < x1);
                ln_mode[MODE_YDEC_BIT] = (y2 < y1);
                ln_cx = coord_t'(x1);
                ln_cy = coord_t'(y1);
                ln_gx = coord_t'(x2);
                ln_gy = coord_t'(y2);
            end
            ln_busy = 1'b1;
        end else begin
            if (!ln_busy) begin
                r.status = ST_IDLE;
                return r;
            end
            // One step: straight lines move along their axis; on a staircase the error sign picks the axis.
            if (ln_mode == MODE_VERT) begin
                ln_cy = ln_cy + COORD_ONE;
            end else if (ln_mode == MODE_HORZ) begin
                ln_cx = ln_cx + COORD_ONE;
            end else if (ln_err >= 0) begin
                ln_cx  = ln_mode[MODE_XDEC_BIT] ? ln_cx - COORD_ONE : ln_cx + COORD_ONE;
                ln_err = ln_err - ln_dy;
            end else begin
                ln_cy  = ln_mode[MODE_YDEC_BIT] ? ln_cy - COORD_ONE : ln_cy + COORD_ONE;
                ln_err = ln_err + ln_dx;
            end
        end
        r.status      = ST_PIXEL;
        r.pixel_x     = ln_cx;
        r.pixel_y     = ln_cy;
        r.pixel_color = ln_color;
        r.final_pixel = (ln_cx == ln_gx) && (ln_cy == ln_gy);
        if (r.final_pixel)
            ln_busy = 1'b0;
        return r;
    endfunction

    // Print one mismatch line and count it; cap the printing, never the count.
    task automatic report_pixel_error(input string msg);
        pixel_errors++;
        if (pixel_errors <= 100)
            $display("MISMATCH at result %0d: %s", pixels_seen, msg);
    endtask

    // Stimulus builders.
    function automatic in_item_t rand_tick();
        in_item_t t;
        t.action     = ACT_TICK;
        t.start_x    = coord_t'($urandom);
        t.start_y    = coord_t'($urandom);
        t.end_x      = coord_t'($urandom);
        t.end_y      = coord_t'($urandom);
        t.line_color = color_t'($urandom);
        return t;
    endfunction

    task automatic queue_ticks(input int n);
        repeat (n) line_cmds.push_back(rand_tick());
    endtask

    task automatic queue_start(input int x1, input int y1, input int x2, input int y2,
                               input int color);
        in_item_t t;
        t.action     = ACT_START;
        t.start_x    = coord_t'(x1);
        t.start_y    = coord_t'(y1);
        t.end_x      = coord_t'(x2);
        t.end_y      = coord_t'(y2);
        t.line_color = color_t'(color);
        line_cmds.push_back(t);
    endtask

    function automatic int pick_near(input int c, input int span, input int lim);
        int v;
        v = c + int'($urandom_range(0, 2 * span)) - span;
        if (v < 0)
            v = 0;
        if (v > lim)
            v = lim;
        return v;
    endfunction

    // Queue one random episode: mostly complete lines, some abandoned ones,
    // rejected starts where the limits leave room, and a little noise.
    task automatic queue_random_episode();
        int kind, span, n, x1, y1, x2, y2;
        kind = $urandom_range(0, 99);
        if (kind < 6) begin
            if ($urandom_range(0, 1))
                queue_ticks(1);
            else
                queue_start($urandom_range(0, 1023), $urandom_range(0, 1023),
                            $urandom_range(0, 1023), $urandom_range(0, 1023), $urandom);
            return;
        end
        span = ($urandom_range(0, 59) == 0) ? 100 : 12;
        x1 = $urandom_range(0, lim_x);
        y1 = $urandom_range(0, lim_y);
        x2 = pick_near(x1, span, lim_x);
        y2 = pick_near(y1, span, lim_y);
        if ($urandom_range(0, 4) == 0)
            x2 = x1;
        else if ($urandom_range(0, 4) == 0)
            y2 = y1;
        if (kind < 16 && (lim_x < 1023 || lim_y < 1023)) begin
            // Push exactly one coordinate past its limit.
            if (lim_x < 1023 && (lim_y == 1023 || $urandom_range(0, 1))) begin
                if ($urandom_range(0, 1))
                    x1 = $urandom_range(lim_x + 1, 1023);
                else
                    x2 = $urandom_range(lim_x + 1, 1023);
            end else begin
                if ($urandom_range(0, 1))
                    y1 = $urandom_range(lim_y + 1, 1023);
                else
                    y2 = $urandom_range(lim_y + 1, 1023);
            end
            queue_start(x1, y1, x2, y2, $urandom);
            queue_ticks($urandom_range(0, 2));
            return;
        end
        queue_start(x1, y1, x2, y2, $urandom);
        n = ((x2 >= x1) ? x2 - x1 : x1 - x2) + ((y2 >= y1) ? y2 - y1 : y1 - y2);
        if (kind < 30)
            n = $urandom_range(0, n);          // abandon part way
        else if ($urandom_range(0, 2) == 0)
            n = n + $urandom_range(1, 2);      // run into idle ticks
        queue_ticks(n);
    endtask

    // Write both limit registers back to back; only called while the block is idle.
    task automatic set_panel_limits(input coord_t new_x, input coord_t new_y);
        cfg_valid <= 1'b1;
        cfg_index <= REG_X_LIMIT;
        cfg_data  <= new_x;
        do @(posedge aclk); while (!cfg_ready);
        lim_x = new_x;
        cfg_index <= REG_Y_LIMIT;
        cfg_data  <= new_y;
        do @(posedge aclk); while (!cfg_ready);
        lim_y = new_y;
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued item is accepted, unless input is held, and every awaited
    // pixel has arrived. Check on the falling edge, where driver and monitor have settled,
    // then return on a rising edge.
    task automatic wait_for_results();
        while ((line_cmds.size() != 0 && !hold_input) || s_valid ||
               awaited_pixels.size() != 0)
            @(negedge aclk);
        @(posedge aclk);
    endtask

    // Driver: send in bursts with random gaps; predict each transaction as it is accepted.
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                awaited_pixels.push_back(trace_line_step(s_data));
            // Hold valid and payload until the current transaction is accepted.
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left = gap_left - 1;
                    s_valid <= 1'b0;
                end else if (line_cmds.size() != 0 && !hold_input) begin
                    s_data  <= line_cmds.pop_front();
                    s_valid <= 1'b1;
                    burst_left = burst_left - 1;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        // A quarter of bursts run straight into the next one.
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: alternate ready runs and stalls of random length, with long clean runs.
    int ready_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else begin
            m_ready <= !m_ready;
            if (m_ready)
                ready_left <= $urandom_range(0, 4);
            else
                ready_left <= ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(0, 6);
        end
    end

    // Monitor: compare each accepted result with the oldest awaited pixel.
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_pixels.size() == 0) begin
                report_pixel_error($sformatf("result with nothing awaited, status %0d",
                                             m_data.status));
            end else begin
                want = awaited_pixels.pop_front();
                if (m_data.status !== want.status)
                    report_pixel_error($sformatf("status got %0d want %0d",
                                                 m_data.status, want.status));
                if (m_data.pixel_x !== want.pixel_x)
                    report_pixel_error($sformatf("pixel_x got %0d want %0d",
                                                 m_data.pixel_x, want.pixel_x));
                if (m_data.pixel_y !== want.pixel_y)
                    report_pixel_error($sformatf("pixel_y got %0d want %0d",
                                                 m_data.pixel_y, want.pixel_y));
                if (m_data.pixel_color !== want.pixel_color)
                    report_pixel_error($sformatf("pixel_color got %h want %h",
                                                 m_data.pixel_color, want.pixel_color));
                if (m_data.final_pixel !== want.final_pixel)
                    report_pixel_error($sformatf("final_pixel got %0d want %0d",
                                                 m_data.final_pixel, want.final_pixel));
            end
            pixels_seen++;
        end
    end

    // Stimulus sequence.
    initial begin
        coord_t phase_x[5];
        coord_t phase_y[5];
        phase_x = '{coord_t'(1023), X_LIMIT_RESET, coord_t'(1023), coord_t'(100), '0};
        phase_y = '{coord_t'(1023), Y_LIMIT_RESET, coord_t'(63), coord_t'(1023), '0};
        phase_x[4] = coord_t'($urandom_range(1, 1022));
        phase_y[4] = coord_t'($urandom_range(1, 1022));

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset limits: idle tick, a single point on both limits and an idle tick, a short line
        // cut off by a rejected start on the x limit, then idle again and a reject on the y limit.
        queue_ticks(1);
        queue_start(240, 320, 240, 320, 16'hFFFF);
        queue_ticks(1);
        queue_start(0, 5, 2, 5, 16'hF800);
        queue_ticks(1);
        queue_start(241, 0, 0, 0, 16'h1234);
        queue_ticks(1);
        queue_start(0, 0, 0, 321, 16'h4321);
        wait_for_results();

        // Full panel: edge coordinates, reversed straight lines, both staircase
        // directions, and a new start abandoning a long diagonal.
        set_panel_limits(coord_t'(1023), coord_t'(1023));
        queue_start(1023, 0, 1023, 2, 16'h07E0);
        queue_ticks(2);
        queue_start(5, 1023, 0, 1023, 16'h001F);
        queue_ticks(1);
        queue_start(0, 0, 1023, 1023, 16'h0000);
        queue_ticks(2);
        queue_start(1023, 1023, 1022, 1021, 16'hAAAA);
        queue_ticks(3);
        queue_start(7, 9, 7, 7, 16'h5555);
        queue_ticks(3);
        wait_for_results();

        // Zero limits: only the origin is drawable.
        set_panel_limits('0, '0);
        queue_start(0, 0, 0, 0, 16'h07E0);
        queue_start(0, 1, 0, 0, 16'hFFFF);
        queue_ticks(1);
        wait_for_results();

        // Random phases, each under its own limits.
        for (int p = 0; p < 5; p++) begin
            set_panel_limits(phase_x[p], phase_y[p]);
            while (line_cmds.size() < 190)
                queue_random_episode();
            if (p == 2) begin
                // Halfway through, stop sending until the block has fully drained.
                while (line_cmds.size() > 95)
                    @(posedge aclk);
                hold_input <= 1'b1;
                @(posedge aclk);
                wait_for_results();
                hold_input <= 1'b0;
                @(posedge aclk);
            end
            wait_for_results();
        end

        // Let any stray result surface before the verdict.
        repeat (10) @(posedge aclk);
        if (pixel_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #3000000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
